// ===== rtl/block_mapped_flash_translation_macros.svh =====
// Assertion macros for the block-mapped flash translation block.
// Used by the top level only; no other dependencies.
`ifndef BLOCK_MAPPED_FLASH_TRANSLATION_MACROS_SVH
`define BLOCK_MAPPED_FLASH_TRANSLATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bmft_pkg.sv =====
// Shared constants and types of the block-mapped flash translation block.
// No dependencies.
`timescale 1ns / 1ps

package bmft_pkg;

  // Fixed request and response field widths.
  localparam int LPN_W   = 11;
  localparam int VALUE_W = 32;

  // Defaults of the top level parameters.
  localparam int NUM_BLOCKS_DEF    = 64;
  localparam int PAGES_PER_BLK_DEF = 32;
  localparam int DATA_WIDTH_DEF    = 32;

  // Operation codes.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Status codes.
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MAP,
    ST_PREAD,
    ST_COPY,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/bmft_if.sv =====
// Request and response channel interfaces of the flash translation block.
// Depends on bmft_pkg.
`timescale 1ns / 1ps

interface bmft_req_if;
  import bmft_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [LPN_W-1:0]   logical_page;
  logic [VALUE_W-1:0] write_value;

  modport source (output valid, operation, logical_page, write_value, input ready);
  modport sink   (input valid, operation, logical_page, write_value, output ready);
endinterface

interface bmft_rsp_if;
  import bmft_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_value;
  logic               page_erased;
  logic               status;
  logic [VALUE_W-1:0] copied_pages_total;

  modport source (output valid, read_value, page_erased, status, copied_pages_total,
                  input ready);
  modport sink   (input valid, read_value, page_erased, status, copied_pages_total,
                  output ready);
endinterface

// ===== rtl/bmft_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// Defaults come from bmft_pkg.
`timescale 1ns / 1ps

module bmft_ram #(
  parameter int WIDTH = bmft_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = bmft_pkg::NUM_BLOCKS_DEF * bmft_pkg::PAGES_PER_BLK_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/block_mapped_flash_translation.sv =====
// Top level of the block-mapped flash translation block: FSM, block map and page store.
// Depends on bmft_pkg, bmft_if, bmft_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "block_mapped_flash_translation_macros.svh"

// Block-mapped flash translation over a modeled NAND array of NUM_BLOCKS physical
// blocks of PAGES_PER_BLK pages each. A request reads or writes one logical page; the
// logical block is mapped to a physical block on its first write, handed out in order
// from block 0, with the last block held back as the copy-back spare. Writing a page
// that is already programmed moves the other programmed pages of the block to the
// spare, places the new data there, remaps the logical block and turns the old block
// into the spare; copied_pages_total counts the moved pages. Out-of-range pages and a
// first write with no fresh block left come back with status set and change nothing.
// Timing: after reset the block map is cleared with the request channel held off.
// Then one request is in flight at a time: an out-of-range page goes from the lookup
// straight to the response; other requests then read the block map, and reads of
// programmed pages also read the page store, both with registered read data. A
// copy-back walks the old block one page per cycle through the page store. A finished
// response waits in the output register while the next request is taken.
module block_mapped_flash_translation #(
  parameter int NUM_BLOCKS    = bmft_pkg::NUM_BLOCKS_DEF,
  parameter int PAGES_PER_BLK = bmft_pkg::PAGES_PER_BLK_DEF,
  parameter int DATA_WIDTH    = bmft_pkg::DATA_WIDTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  bmft_req_if.sink     req_i,
  bmft_rsp_if.source   rsp_o
);
  import bmft_pkg::*;

  localparam int BLK_W     = $clog2(NUM_BLOCKS);
  localparam int OFF_W     = $clog2(PAGES_PER_BLK);
  localparam int PAGES     = NUM_BLOCKS * PAGES_PER_BLK;
  localparam int PAGE_AW   = $clog2(PAGES);
  // Split of the page number by reciprocal multiplication, exact over LPN_W bits.
  localparam int DIV_SHIFT = LPN_W + OFF_W;
  localparam int RECIP     = ((1 << DIV_SHIFT) + PAGES_PER_BLK - 1) / PAGES_PER_BLK;
  localparam int PROD_W    = LPN_W + DIV_SHIFT + 1;

  // One map entry per logical block; prog marks the programmed pages of pblk.
  typedef struct packed {
    logic                     valid;
    logic [BLK_W-1:0]         pblk;
    logic [PAGES_PER_BLK-1:0] prog;
  } map_entry_t;

  localparam int MAP_W = $bits(map_entry_t);

  function automatic logic [PAGE_AW-1:0] page_addr(input logic [BLK_W-1:0] blk,
                                                   input logic [OFF_W-1:0] off);
    return PAGE_AW'(blk) * PAGE_AW'(PAGES_PER_BLK) + PAGE_AW'(off);
  endfunction

  state_e state_q, state_d;

  // Control state.
  logic [BLK_W-1:0]   clr_idx_q;
  logic [BLK_W-1:0]   fresh_q;
  logic [BLK_W-1:0]   spare_q;
  logic [VALUE_W-1:0] cnt_q;
  logic [OFF_W-1:0]   ptr_q;
  logic               stg_vld_q;
  logic               out_valid_q;

  // Request and work registers.
  logic                     op_q;
  logic [LPN_W-1:0]         lpn_q;
  logic [LPN_W-1:0]         lblk_q;
  logic [OFF_W-1:0]         off_q;
  logic [DATA_WIDTH-1:0]    wval_q;
  logic [BLK_W-1:0]         victim_q;
  logic [PAGES_PER_BLK-1:0] vmask_q;
  logic                     stg_new_q;
  logic [OFF_W-1:0]         stg_idx_q;
  logic [VALUE_W-1:0]       res_value_q;
  logic                     res_erased_q;
  logic                     res_status_q;
  logic [VALUE_W-1:0]       out_value_q;
  logic                     out_erased_q;
  logic                     out_status_q;
  logic [VALUE_W-1:0]       out_cnt_q;

  // Memory ports.
  logic                  map_we;
  logic [BLK_W-1:0]      map_waddr;
  map_entry_t            map_wdata;
  logic [BLK_W-1:0]      map_raddr;
  map_entry_t            map_rdata;
  logic [MAP_W-1:0]      map_rdata_raw;
  logic                  page_we;
  logic [PAGE_AW-1:0]    page_waddr;
  logic [DATA_WIDTH-1:0] page_wdata;
  logic [PAGE_AW-1:0]    page_raddr;
  logic [DATA_WIDTH-1:0] page_rdata;

  // Decode helpers.
  logic                     req_acc;
  logic                     out_free;
  logic [PROD_W-1:0]        div_prod;
  logic [LPN_W-1:0]         blk_base;
  logic                     out_of_range;
  logic [PAGES_PER_BLK-1:0] off_bit;
  logic                     page_hit;
  logic                     fresh_empty;
  logic                     copy_last;

  bmft_ram #(
    .WIDTH (MAP_W),
    .DEPTH (NUM_BLOCKS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata_raw)
  );

  bmft_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (PAGES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (page_we),
    .waddr_i (page_waddr),
    .wdata_i (page_wdata),
    .raddr_i (page_raddr),
    .rdata_o (page_rdata)
  );

  assign map_rdata = map_entry_t'(map_rdata_raw);

  // Handshakes: take a new request when idle, or while handing off the previous result.
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
  assign req_acc     = req_i.valid && req_i.ready;

  // Split the logical page: block by reciprocal multiply, offset from the registered block.
  assign div_prod     = PROD_W'(req_i.logical_page) * PROD_W'(RECIP);
  assign blk_base     = lblk_q * LPN_W'(PAGES_PER_BLK);
  assign out_of_range = 32'(lblk_q) >= 32'(NUM_BLOCKS);

  assign off_bit     = {{(PAGES_PER_BLK-1){1'b0}}, 1'b1} << off_q;
  assign page_hit    = map_rdata.valid && map_rdata.prog[off_q];
  assign fresh_empty = fresh_q == BLK_W'(NUM_BLOCKS - 1);
  assign copy_last   = ptr_q == OFF_W'(PAGES_PER_BLK - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == BLK_W'(NUM_BLOCKS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_acc) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = out_of_range ? ST_DONE : ST_MAP;
      end
      ST_MAP: begin
        if (op_q == OP_READ) begin
          state_d = page_hit ? ST_PREAD : ST_DONE;
        end else begin
          state_d = page_hit ? ST_COPY : ST_DONE;
        end
      end
      ST_PREAD: state_d = ST_DONE;
      ST_COPY: begin
        if (copy_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = req_acc ? ST_LOOKUP : ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Memory accesses for each state.
  always_comb begin
    map_we     = 1'b0;
    map_waddr  = BLK_W'(lblk_q);
    map_wdata  = '0;
    map_raddr  = BLK_W'(lblk_q);
    page_we    = 1'b0;
    page_waddr = page_addr(spare_q, stg_idx_q);
    page_wdata = stg_new_q ? wval_q : page_rdata;
    page_raddr = page_addr(map_rdata.pblk, off_q);
    case (state_q)
      ST_CLEAR: begin
        // Sweep the map to unmapped, one entry a cycle.
        map_we    = 1'b1;
        map_waddr = clr_idx_q;
      end
      ST_MAP: begin
        if (op_q == OP_WRITE) begin
          if (!map_rdata.valid) begin
            // First write to the block: take the next fresh block.
            if (!fresh_empty) begin
              map_we          = 1'b1;
              map_wdata.valid = 1'b1;
              map_wdata.pblk  = fresh_q;
              map_wdata.prog  = off_bit;
              page_we         = 1'b1;
              page_waddr      = page_addr(fresh_q, off_q);
              page_wdata      = wval_q;
            end
          end else if (!map_rdata.prog[off_q]) begin
            // Erased page of a mapped block: program in place.
            map_we          = 1'b1;
            map_wdata.valid = 1'b1;
            map_wdata.pblk  = map_rdata.pblk;
            map_wdata.prog  = map_rdata.prog | off_bit;
            page_we         = 1'b1;
            page_waddr      = page_addr(map_rdata.pblk, off_q);
            page_wdata      = wval_q;
          end else begin
            // Overwrite: remap to the spare now, pages follow during the walk.
            map_we          = 1'b1;
            map_wdata.valid = 1'b1;
            map_wdata.pblk  = spare_q;
            map_wdata.prog  = map_rdata.prog;
          end
        end
      end
      ST_COPY: begin
        page_raddr = page_addr(victim_q, ptr_q);
        page_we    = stg_vld_q;
      end
      ST_DRAIN: begin
        page_we = stg_vld_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      fresh_q     <= '0;
      spare_q     <= BLK_W'(NUM_BLOCKS - 1);
      cnt_q       <= '0;
      ptr_q       <= '0;
      stg_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
      // Advance the fresh pointer on each successful first write.
      if ((state_q == ST_MAP) && (op_q == OP_WRITE) && !map_rdata.valid && !fresh_empty) begin
        fresh_q <= fresh_q + 1'b1;
      end
      if (state_q == ST_MAP) ptr_q <= '0;
      else if (state_q == ST_COPY) ptr_q <= ptr_q + 1'b1;
      // Stage a page write when the walk hits the new page or a programmed one.
      stg_vld_q <= (state_q == ST_COPY) && ((ptr_q == off_q) || vmask_q[ptr_q]);
      if (((state_q == ST_COPY) || (state_q == ST_DRAIN)) && stg_vld_q && !stg_new_q) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // Old block becomes the spare once the walk is done.
      if (state_q == ST_DRAIN) spare_q <= victim_q;
      if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Request, work and result registers.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q   <= req_i.operation;
      lpn_q  <= req_i.logical_page;
      wval_q <= DATA_WIDTH'(req_i.write_value);
      lblk_q <= div_prod[DIV_SHIFT +: LPN_W];
    end
    stg_new_q <= ptr_q == off_q;
    stg_idx_q <= ptr_q;
    case (state_q)
      ST_LOOKUP: begin
        off_q        <= OFF_W'(lpn_q - blk_base);
        res_value_q  <= '0;
        res_erased_q <= 1'b0;
        res_status_q <= out_of_range ? STATUS_REJECT : STATUS_DONE;
      end
      ST_MAP: begin
        if (op_q == OP_READ) begin
          res_erased_q <= !page_hit;
        end else if (!map_rdata.valid && fresh_empty) begin
          res_status_q <= STATUS_REJECT;
        end
        victim_q <= map_rdata.pblk;
        vmask_q  <= map_rdata.prog;
      end
      ST_PREAD: res_value_q <= VALUE_W'(page_rdata);
      default: ;
    endcase
    // Hold the response until taken.
    if ((state_q == ST_DONE) && out_free) begin
      out_value_q  <= res_value_q;
      out_erased_q <= res_erased_q;
      out_status_q <= res_status_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.read_value         = out_value_q;
  assign rsp_o.page_erased        = out_erased_q;
  assign rsp_o.status             = out_status_q;
  assign rsp_o.copied_pages_total = out_cnt_q;

  // Checks.
  `BMFT_ASSERT_NEXT(a_acc_to_lookup, clk_i, rst_ni, req_acc, state_q == ST_LOOKUP,
                    "request accepted without lookup")
  `BMFT_ASSERT_NOW(a_copy_target, clk_i, rst_ni,
                   (state_q == ST_COPY) || (state_q == ST_DRAIN), spare_q != victim_q,
                   "copy-back target equals source block")
  `BMFT_ASSERT_NEXT(a_cnt_stable, clk_i, rst_ni,
                    (state_q != ST_COPY) && (state_q != ST_DRAIN), $stable(cnt_q),
                    "copy counter moved outside copy-back")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the block-mapped flash translation block.
// Depends on bmft_pkg, the bmft_req_if / bmft_rsp_if interfaces and the top level RTL.
`timescale 1ns / 1ps

module tb_top;
  import bmft_pkg::*;

  localparam int NUM_BLOCKS    = NUM_BLOCKS_DEF;
  localparam int PAGES_PER_BLK = PAGES_PER_BLK_DEF;
  localparam int TOTAL_PAGES   = NUM_BLOCKS * PAGES_PER_BLK;
  localparam int RANDOM_ITEMS  = 1232;
  // Longest request is a copy-back; leave room for it plus the output register.
  localparam int TAIL_CYCLES   = PAGES_PER_BLK + 8;

  typedef struct {
    logic               operation;
    logic [LPN_W-1:0]   logical_page;
    logic [VALUE_W-1:0] write_value;
    bit                 wait_idle;      // hold back until every response is in
    int unsigned        src_idle_pct;
    int unsigned        dst_stall_pct;
  } page_request_t;

  typedef struct {
    logic [VALUE_W-1:0] read_value;
    logic               page_erased;
    logic               status;
    logic [VALUE_W-1:0] copied_pages_total;
  } page_response_t;

  logic clk_i;
  logic rst_ni;

  bmft_req_if req_bus ();
  bmft_rsp_if rsp_bus ();

  block_mapped_flash_translation #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .PAGES_PER_BLK (PAGES_PER_BLK),
    .DATA_WIDTH    (DATA_WIDTH_DEF)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow copy of the flash: block map, page contents, programmed bits.
  bit                 map_valid    [NUM_BLOCKS];
  int unsigned        map_block    [NUM_BLOCKS];
  logic [VALUE_W-1:0] page_data    [TOTAL_PAGES];
  bit                 page_written [TOTAL_PAGES];
  int unsigned        fresh_block = 0;
  int unsigned        spare_block = NUM_BLOCKS - 1;
  logic [VALUE_W-1:0] moved_pages = '0;

  page_request_t  pending_requests [$];
  page_response_t predicted_responses [$];

  int unsigned src_pct_of [4] = '{0, 49, 0, 33};
  int unsigned dst_pct_of [4] = '{0, 0, 49, 33};
  int unsigned gen_phase = 0;
  bit          gen_wait_idle = 1'b0;
  int unsigned issued = 0;

  int unsigned rsp_stall_pct = 0;
  logic        req_taken;
  int unsigned response_count = 0;
  int unsigned error_count = 0;

  // Apply one request to the shadow flash and return the response it must produce.
  function automatic page_response_t translate_request(logic op, logic [LPN_W-1:0] lpn,
                                                       logic [VALUE_W-1:0] wdata);
    page_response_t rsp;
    int unsigned lblk, off, phys, dst;
    rsp = '{read_value: '0, page_erased: 1'b0, status: STATUS_DONE, copied_pages_total: '0};
    lblk = int'(lpn) / PAGES_PER_BLK;
    off  = int'(lpn) % PAGES_PER_BLK;
    if (lblk >= NUM_BLOCKS) begin
      rsp.status = STATUS_REJECT;
    end else if (op == OP_READ) begin
      if (!map_valid[lblk]) begin
        rsp.page_erased = 1'b1;
      end else if (page_written[map_block[lblk] * PAGES_PER_BLK + off]) begin
        rsp.read_value = page_data[map_block[lblk] * PAGES_PER_BLK + off];
      end else begin
        rsp.page_erased = 1'b1;
      end
    end else if (!map_valid[lblk]) begin
      // First write to this logical block: take a fresh block if any is left.
      if (fresh_block >= NUM_BLOCKS - 1) begin
        rsp.status = STATUS_REJECT;
      end else begin
        map_block[lblk] = fresh_block;
        map_valid[lblk] = 1'b1;
        page_data[fresh_block * PAGES_PER_BLK + off]    = wdata;
        page_written[fresh_block * PAGES_PER_BLK + off] = 1'b1;
        fresh_block++;
      end
    end else begin
      phys = map_block[lblk];
      if (!page_written[phys * PAGES_PER_BLK + off]) begin
        page_data[phys * PAGES_PER_BLK + off]    = wdata;
        page_written[phys * PAGES_PER_BLK + off] = 1'b1;
      end else begin
        // Copy-back: move the other programmed pages to the spare, then swap roles.
        dst = spare_block;
        for (int i = 0; i < PAGES_PER_BLK; i++) begin
          page_written[dst * PAGES_PER_BLK + i] = 1'b0;
        end
        for (int i = 0; i < PAGES_PER_BLK; i++) begin
          if (i == off) begin
            page_data[dst * PAGES_PER_BLK + i]    = wdata;
            page_written[dst * PAGES_PER_BLK + i] = 1'b1;
          end else if (page_written[phys * PAGES_PER_BLK + i]) begin
            page_data[dst * PAGES_PER_BLK + i]    = page_data[phys * PAGES_PER_BLK + i];
            page_written[dst * PAGES_PER_BLK + i] = 1'b1;
            moved_pages++;
          end
        end
        for (int i = 0; i < PAGES_PER_BLK; i++) begin
          page_written[phys * PAGES_PER_BLK + i] = 1'b0;
        end
        spare_block     = phys;
        map_block[lblk] = dst;
      end
    end
    rsp.copied_pages_total = moved_pages;
    return rsp;
  endfunction

  task automatic report_mismatch(int unsigned idx, string field, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    $display("MISMATCH response %0d %s: got 0x%08h, want 0x%08h", idx, field, got, want);
    error_count++;
  endtask

  // Queue one request with the idling of the current phase; every fourth stretch of
  // twenty runs without any idling.
  task automatic add_request(logic op, logic [LPN_W-1:0] lpn, logic [VALUE_W-1:0] wdata);
    page_request_t item;
    bit quiet;
    quiet = (issued % 80) < 20;
    item.operation     = op;
    item.logical_page  = lpn;
    item.write_value   = wdata;
    item.wait_idle     = gen_wait_idle;
    item.src_idle_pct  = quiet ? 0 : src_pct_of[gen_phase];
    item.dst_stall_pct = quiet ? 0 : dst_pct_of[gen_phase];
    pending_requests.push_back(item);
    gen_wait_idle = 1'b0;
    issued++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive requests at the falling edge. Hold a request until it is taken; a request
  // flagged wait_idle is held back until every predicted response has arrived.
  always @(negedge clk_i or negedge rst_ni) begin : drive_requests
    page_request_t item;
    logic present;
    if (!rst_ni) begin
      req_bus.valid        <= 1'b0;
      req_bus.operation    <= OP_READ;
      req_bus.logical_page <= '0;
      req_bus.write_value  <= '0;
    end else if (!req_bus.valid || req_taken) begin
      present = 1'b0;
      if (pending_requests.size() != 0) begin
        item = pending_requests[0];
        rsp_stall_pct <= item.dst_stall_pct;
        if ((!item.wait_idle || predicted_responses.size() == 0) &&
            $urandom_range(99) >= item.src_idle_pct) begin
          void'(pending_requests.pop_front());
          present = 1'b1;
          req_bus.operation    <= item.operation;
          req_bus.logical_page <= item.logical_page;
          req_bus.write_value  <= item.write_value;
        end
      end
      req_bus.valid <= present;
    end
  end

  // Stall the response channel at random.
  always @(negedge clk_i or negedge rst_ni) begin : drive_ready
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Sample both channels at the rising edge: check the response first, then predict
  // the request taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    page_response_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_bus.valid && req_bus.ready;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (predicted_responses.size() == 0) begin
          report_mismatch(response_count, "unexpected response", rsp_bus.read_value, '0);
        end else begin
          want = predicted_responses.pop_front();
          if (rsp_bus.read_value !== want.read_value)
            report_mismatch(response_count, "read_value", rsp_bus.read_value,
                            want.read_value);
          if (rsp_bus.page_erased !== want.page_erased)
            report_mismatch(response_count, "page_erased", VALUE_W'(rsp_bus.page_erased),
                            VALUE_W'(want.page_erased));
          if (rsp_bus.status !== want.status)
            report_mismatch(response_count, "status", VALUE_W'(rsp_bus.status),
                            VALUE_W'(want.status));
          if (rsp_bus.copied_pages_total !== want.copied_pages_total)
            report_mismatch(response_count, "copied_pages_total",
                            rsp_bus.copied_pages_total, want.copied_pages_total);
        end
        response_count++;
      end
      if (req_bus.valid && req_bus.ready) begin
        predicted_responses.push_back(translate_request(req_bus.operation,
                                                        req_bus.logical_page,
                                                        req_bus.write_value));
      end
    end
  end

  initial begin : run_test
    int unsigned phase_end, hot_blk, burst_len, off;
    int unsigned hot_list [4];
    logic op;
    hot_list = '{0, 17, 40, NUM_BLOCKS - 1};
    rst_ni = 1'b0;

    // Directed: unmapped reads, page extremes, data extremes, in-place programming,
    // copy-back with and without other programmed pages.
    add_request(OP_READ,  11'd0,    32'h0);
    add_request(OP_READ,  11'd2047, 32'h0);
    add_request(OP_WRITE, 11'd0,    32'h0000_0000);
    add_request(OP_READ,  11'd0,    32'hFFFF_FFFF);
    add_request(OP_READ,  11'd1,    32'h0);
    add_request(OP_WRITE, 11'd31,   32'hFFFF_FFFF);
    add_request(OP_READ,  11'd31,   32'h0);
    add_request(OP_WRITE, 11'd5,    32'hA5A5_A5A5);
    add_request(OP_WRITE, 11'd0,    32'h1234_5678);
    add_request(OP_READ,  11'd0,    32'h0);
    add_request(OP_READ,  11'd5,    32'h0);
    add_request(OP_READ,  11'd31,   32'h0);
    add_request(OP_WRITE, 11'd5,    32'h5A5A_5A5A);
    add_request(OP_READ,  11'd5,    32'h0);
    add_request(OP_WRITE, 11'd2047, 32'h8000_0000);
    add_request(OP_READ,  11'd2047, 32'h0);
    add_request(OP_WRITE, 11'd2047, 32'h7FFF_FFFF);
    add_request(OP_READ,  11'd2047, 32'h0);
    add_request(OP_READ,  11'd2016, 32'h0);
    add_request(OP_WRITE, 11'd1024, $urandom);
    add_request(OP_READ,  11'd1024, 32'h0);

    for (int ph = 0; ph < 4; ph++) begin
      gen_phase     = ph;
      gen_wait_idle = 1'b1;
      phase_end     = issued + RANDOM_ITEMS / 4;
      // Sweep every logical block once to use up the fresh blocks; the last
      // unmapped one must be turned away.
      if (ph == 1) begin
        for (int b = 0; b < NUM_BLOCKS; b++) begin
          add_request(OP_WRITE, LPN_W'(b * PAGES_PER_BLK + $urandom_range(PAGES_PER_BLK - 1)),
                      $urandom);
        end
      end
      while (issued < phase_end) begin
        if ($urandom_range(9) < 7) begin
          // Burst on one block, mostly a hot one with offsets packed low so that
          // copy-backs find many programmed pages.
          hot_blk   = ($urandom_range(3) == 0) ? $urandom_range(NUM_BLOCKS - 1)
                                               : hot_list[$urandom_range(3)];
          burst_len = $urandom_range(10, 3);
          for (int k = 0; k < burst_len; k++) begin
            off = $urandom_range(1) ? $urandom_range(7) : $urandom_range(PAGES_PER_BLK - 1);
            op  = ($urandom_range(99) < 55) ? OP_WRITE : OP_READ;
            add_request(op, LPN_W'(hot_blk * PAGES_PER_BLK + off), $urandom);
          end
        end else begin
          op = ($urandom_range(99) < 60) ? OP_WRITE : OP_READ;
          add_request(op, LPN_W'($urandom_range(TOTAL_PAGES - 1)), $urandom);
        end
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all requests out, all responses in, then let the block settle.
    while (pending_requests.size() != 0 || req_bus.valid || predicted_responses.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bmft_pkg.sv
rtl/bmft_if.sv
rtl/bmft_ram.sv
rtl/block_mapped_flash_translation.sv
tb/sv/tb_top.sv
